[src/org_pkg.sv]
`default_nettype none

package org_pkg;

  // Size of the symbol override table, one cell per entry.
  localparam int unsigned SYMBOL_ENTRIES = 64;

  localparam int unsigned SYM_W   = 64;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned REF_W   = 32;
  localparam int unsigned NOTL_W  = 64;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    ACT_ENTER   = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_CANCEL  = 3'd2,
    ACT_ENABLE  = 3'd3,
    ACT_DISABLE = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    REJ_NONE         = 4'd0,
    REJ_HALT         = 4'd1,
    REJ_CANCEL_ONLY  = 4'd2,
    REJ_SYMBOL_OFF   = 4'd3,
    REJ_QTY          = 4'd4,
    REJ_PRICE        = 4'd5,
    REJ_MAX_QTY      = 4'd6,
    REJ_MAX_NOTIONAL = 4'd7,
    REJ_TABLE_FULL   = 4'd8
  } reject_t;

  typedef enum logic [2:0] {
    REG_GLOBAL_HALT      = 3'd0,
    REG_CANCEL_ONLY      = 3'd1,
    REG_DEFAULT_ENABLE   = 3'd2,
    REG_MAX_ORDER_QTY    = 3'd3,
    REG_MAX_ORDER_NOTL   = 3'd4,
    REG_MAX_VALID_QTY    = 3'd5,
    REG_MAX_VALID_PRICE  = 3'd6
  } cfg_reg_t;

  // Command broadcast from the sequencer to every table cell.
  typedef struct packed {
    logic             look;
    logic             write;
    logic             clear;
    logic             found;
    logic             value;
    logic [SYM_W-1:0] symbol;
  } org_cell_ctrl_t;

  // Status returned by one table cell.
  typedef struct packed {
    logic used;
    logic hit;
    logic enabled;
  } org_cell_stat_t;

endpackage

`default_nettype wire

[src/org_cell.sv]
`default_nettype none

module org_cell
  import org_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire org_cell_ctrl_t ctrl,
  input  wire logic           prev_used,
  output org_cell_stat_t      stat
);

  logic             used_r;
  logic             hit_r;
  logic             enabled_r;
  logic [SYM_W-1:0] symbol_r;
  logic             first_free;
  logic             alloc;

  // The used entries always form a prefix of the row, so the first free cell
  // is the one whose left neighbor is used and which is not.
  assign first_free = prev_used && !used_r;
  assign alloc      = ctrl.write && !ctrl.found && first_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      if (ctrl.look) begin
        hit_r <= used_r && (symbol_r == ctrl.symbol);
      end
      if (ctrl.clear) begin
        used_r <= 1'b0;
      end else if (alloc) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (alloc || (ctrl.write && ctrl.found && hit_r)) begin
      enabled_r <= ctrl.value;
    end
    if (alloc) begin
      symbol_r <= ctrl.symbol;
    end
  end

  assign stat.used    = used_r;
  assign stat.hit     = hit_r;
  assign stat.enabled = enabled_r;

endmodule

`default_nettype wire

[src/order_risk_gate.sv]
`default_nettype none

// Pre-trade order risk gate. Each item is an enter, replace or cancel check,
// or an enable, disable or clear operation on the symbol override table, and
// every item with a defined action yields exactly one result item; the two
// unused action codes are consumed and yield nothing. The gate handles one
// item at a time. An item is accepted in the idle state, passes through the
// compare state, which does the cell compare and the price-times-quantity
// multiply, and the decision state, which makes the decision and the table
// update, and its result is then shown in the output state. in_stall stays
// high until the result has been taken, so the gate takes no new item before
// the result of the last one has been taken, and out_stall can hold the result
// off. An item with an unused action code is consumed in the idle state. The
// symbol table is a row of SYMBOL_ENTRIES identical cells; each cell holds one
// override entry, compares its symbol in the compare state, and passes its used
// flag to its right neighbor so that the first free cell knows it is next to be
// allocated. Entries are freed only by clear, which frees them all at once, so
// no clearing pass follows reset. The configuration registers sit behind an
// APB-style port at byte address 8 times the register index and should only be
// written while the gate is idle.
module order_risk_gate
  import org_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_action,
  input  wire logic [REF_W-1:0]      in_user_ref,
  input  wire logic [QTY_W-1:0]      in_order_quantity,
  input  wire logic [PRICE_W-1:0]    in_order_price,
  input  wire logic [SYM_W-1:0]      in_symbol_code,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_rejected,
  output logic [3:0]                 out_reject_code,
  output logic [REF_W-1:0]           out_echo_ref,
  output logic [QTY_W-1:0]           out_echo_quantity,
  output logic [PRICE_W-1:0]         out_echo_price,
  output logic [NOTL_W-1:0]          out_notional,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOK   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic                 global_halt_r;
  logic                 cancel_only_r;
  logic                 default_enable_r;
  logic [QTY_W-1:0]     max_order_qty_r;
  logic [NOTL_W-1:0]    max_order_notl_r;
  logic [QTY_W-1:0]     max_valid_qty_r;
  logic [PRICE_W-1:0]   max_valid_price_r;

  logic                 cfg_write;
  cfg_reg_t             cfg_idx;

  // Item held while it is worked on.
  action_t              item_action_r;
  logic [REF_W-1:0]     item_ref_r;
  logic [QTY_W-1:0]     item_qty_r;
  logic [PRICE_W-1:0]   item_price_r;
  logic [SYM_W-1:0]     item_symbol_r;
  logic [NOTL_W-1:0]    product_r;

  // Result register.
  reject_t              res_code;
  logic [QTY_W-1:0]     res_qty;
  logic [PRICE_W-1:0]   res_price;
  logic [NOTL_W-1:0]    res_notl;
  reject_t              out_code_r;
  logic [REF_W-1:0]     out_ref_r;
  logic [QTY_W-1:0]     out_qty_r;
  logic [PRICE_W-1:0]   out_price_r;
  logic [NOTL_W-1:0]    out_notl_r;

  // Table row.
  org_cell_ctrl_t             cell_ctrl;
  org_cell_stat_t             cell_stat [SYMBOL_ENTRIES];
  logic [SYMBOL_ENTRIES-1:0]  used_vec;
  logic [SYMBOL_ENTRIES-1:0]  hit_vec;
  logic [SYMBOL_ENTRIES-1:0]  on_vec;
  logic                       found;
  logic                       table_full;
  logic                       symbol_on;
  logic                       is_set_op;

  // ---------------------------------------------------------------------
  // Configuration port. Writes land on the access cycle; reads are
  // combinational from the register bank.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_halt_r     <= 1'b0;
      cancel_only_r     <= 1'b0;
      default_enable_r  <= 1'b1;
      max_order_qty_r   <= '1;
      max_order_notl_r  <= '1;
      max_valid_qty_r   <= QTY_W'(999999);
      max_valid_price_r <= PRICE_W'(1999999900);
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_GLOBAL_HALT:     global_halt_r     <= pwdata[0];
        REG_CANCEL_ONLY:     cancel_only_r     <= pwdata[0];
        REG_DEFAULT_ENABLE:  default_enable_r  <= pwdata[0];
        REG_MAX_ORDER_QTY:   max_order_qty_r   <= pwdata[QTY_W-1:0];
        REG_MAX_ORDER_NOTL:  max_order_notl_r  <= pwdata[NOTL_W-1:0];
        REG_MAX_VALID_QTY:   max_valid_qty_r   <= pwdata[QTY_W-1:0];
        REG_MAX_VALID_PRICE: max_valid_price_r <= pwdata[PRICE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_GLOBAL_HALT:     prdata[0]              = global_halt_r;
      REG_CANCEL_ONLY:     prdata[0]              = cancel_only_r;
      REG_DEFAULT_ENABLE:  prdata[0]              = default_enable_r;
      REG_MAX_ORDER_QTY:   prdata[QTY_W-1:0]      = max_order_qty_r;
      REG_MAX_ORDER_NOTL:  prdata[NOTL_W-1:0]     = max_order_notl_r;
      REG_MAX_VALID_QTY:   prdata[QTY_W-1:0]      = max_valid_qty_r;
      REG_MAX_VALID_PRICE: prdata[PRICE_W-1:0]    = max_valid_price_r;
      default:             prdata                 = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer. One item is in flight at a time; the input is held off from
  // acceptance until its result has been taken.
  // ---------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        // Unused action codes are dropped right at acceptance.
        if (in_valid && (in_action <= ACT_CLEAR)) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK:   state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_action_r <= action_t'(in_action);
      item_ref_r    <= in_user_ref;
      item_qty_r    <= in_order_quantity;
      item_price_r  <= in_order_price;
      item_symbol_r <= in_symbol_code;
    end
    if (state_r == ST_LOOK) begin
      product_r <= NOTL_W'(item_qty_r) * NOTL_W'(item_price_r);
    end
  end

  // ---------------------------------------------------------------------
  // Symbol table: a row of cells. The query symbol is broadcast, each cell
  // registers its own match, and the first free cell takes a new entry.
  // ---------------------------------------------------------------------
  assign is_set_op = (item_action_r == ACT_ENABLE) || (item_action_r == ACT_DISABLE);

  always_comb begin
    cell_ctrl.look   = (state_r == ST_LOOK);
    cell_ctrl.write  = (state_r == ST_DECIDE) && is_set_op;
    cell_ctrl.clear  = (state_r == ST_DECIDE) && (item_action_r == ACT_CLEAR);
    cell_ctrl.found  = found;
    cell_ctrl.value  = (item_action_r == ACT_ENABLE);
    cell_ctrl.symbol = item_symbol_r;
  end

  for (genvar gi = 0; gi < SYMBOL_ENTRIES; gi++) begin : g_cell
    logic prev_used;
    if (gi == 0) begin : g_head
      assign prev_used = 1'b1;
    end else begin : g_link
      assign prev_used = cell_stat[gi-1].used;
    end
    org_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .prev_used (prev_used),
      .stat      (cell_stat[gi])
    );
  end

  always_comb begin
    for (int i = 0; i < SYMBOL_ENTRIES; i++) begin
      used_vec[i] = cell_stat[i].used;
      hit_vec[i]  = cell_stat[i].hit;
      on_vec[i]   = cell_stat[i].hit && cell_stat[i].enabled;
    end
  end

  // At most one cell can match, so an OR over the row finds the override.
  assign found      = |hit_vec;
  assign table_full = used_vec[SYMBOL_ENTRIES-1];
  assign symbol_on  = found ? (|on_vec) : default_enable_r;

  // ---------------------------------------------------------------------
  // Decision in priority order, registered into the result.
  // ---------------------------------------------------------------------
  always_comb begin
    res_code  = REJ_NONE;
    res_qty   = '0;
    res_price = '0;
    res_notl  = '0;
    case (item_action_r) inside
      ACT_ENTER, ACT_REPLACE: begin
        res_qty   = item_qty_r;
        res_price = item_price_r;
        if (global_halt_r) begin
          res_code = REJ_HALT;
        end else if (cancel_only_r) begin
          res_code = REJ_CANCEL_ONLY;
        end else if (!symbol_on) begin
          res_code = REJ_SYMBOL_OFF;
        end else if (item_qty_r == '0 || item_qty_r > max_valid_qty_r) begin
          res_code = REJ_QTY;
        end else if (item_price_r == '0 || item_price_r > max_valid_price_r) begin
          res_code = REJ_PRICE;
        end else if (item_qty_r > max_order_qty_r) begin
          res_code = REJ_MAX_QTY;
        end else if (product_r > max_order_notl_r) begin
          res_code = REJ_MAX_NOTIONAL;
          res_notl = product_r;
        end else begin
          res_notl = product_r;
        end
      end
      ACT_CANCEL: begin
        res_qty = item_qty_r;
        if (global_halt_r) begin
          res_code = REJ_HALT;
        end else if (item_qty_r > max_valid_qty_r) begin
          res_code = REJ_QTY;
        end
      end
      ACT_ENABLE, ACT_DISABLE: begin
        // A new symbol with no free cell leaves the table untouched.
        if (!found && table_full) begin
          res_code = REJ_TABLE_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE) begin
      out_code_r  <= res_code;
      out_ref_r   <= item_ref_r;
      out_qty_r   <= res_qty;
      out_price_r <= res_price;
      out_notl_r  <= res_notl;
    end
  end

  assign out_rejected      = (out_code_r != REJ_NONE);
  assign out_reject_code   = out_code_r;
  assign out_echo_ref      = out_ref_r;
  assign out_echo_quantity = out_qty_r;
  assign out_echo_price    = out_price_r;
  assign out_notional      = out_notl_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // A symbol is held by at most one cell, so at most one cell matches.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one table cell matched the symbol");

  // Used cells always form a prefix of the row.
  a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, used_vec} + {{SYMBOL_ENTRIES{1'b0}}, 1'b1}))
    else $error("used table cells are not a contiguous prefix");

  // Notional is reported only for accepted items and notional rejects.
  a_notional_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reject_code != REJ_NONE && out_reject_code != REJ_MAX_NOTIONAL)
      |-> (out_notional == '0))
    else $error("notional shown on an item rejected for another reason");

  // A shown result holds while the output is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_reject_code)
      && $stable(out_notional)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
